[sv/pcr_pkg.sv]
// Shared constants and types for the particle contact resolver.
`timescale 1ns / 1ps
package pcr_pkg;
   localparam int FRAC_BITS   = 12;
   localparam int VEC_W       = 63;
   localparam int PEN_W       = 21;
   localparam int MASS_W      = 16;
   localparam int TOTAL_W     = 17;
   localparam int REST_W      = 16;
   localparam int FACTOR_W    = 17;
   localparam int REST_SHIFT  = 15;
   localparam int DELTA_W     = 37;
   localparam int AXES        = 3;
   localparam int VECS        = 4;
   localparam int LANES       = 12;
   localparam int VEC_VA      = 0;
   localparam int VEC_VB      = 1;
   localparam int VEC_PA      = 2;
   localparam int VEC_PB      = 3;
   localparam logic [FACTOR_W-1:0] REST_ONE = FACTOR_W'(32768);
   localparam logic [DELTA_W-1:0] DELTA_LIMIT = {1'b1, {(DELTA_W-1){1'b0}}};

   typedef struct packed {
      logic valid;
      logic has;
      logic imp;
      logic mov;
   } pcr_flags_type;
endpackage

[sv/pcr_div.sv]
// One pipelined restoring divider lane with saturation and floor rounding.
`timescale 1ns / 1ps
module pcr_div #(
   parameter int COMPONENT_BITS = 21
) (
   input  logic                                   clock,
   input  logic                                   en,
   input  logic [COMPONENT_BITS+39:0]             num,
   input  logic                                   neg,
   input  logic [pcr_pkg::TOTAL_W-1:0]            total,
   output logic signed [COMPONENT_BITS+1:0]       quo
);
   import pcr_pkg::*;

   localparam int CB = COMPONENT_BITS;
   localparam int MW = CB + 40;
   localparam int RW = TOTAL_W + FRAC_BITS + CB;

   logic [RW-1:0]      r_ff [0:CB];
   logic [CB-1:0]      q_ff [0:CB];
   logic [TOTAL_W-1:0] t_ff [0:CB];
   logic               n_ff [0:CB];
   logic               o_ff [0:CB];

   logic [MW-1:0] limit;
   assign limit = MW'({total, {(FRAC_BITS+CB){1'b0}}});

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff[0] <= num[RW-1:0];
         q_ff[0] <= '0;
         t_ff[0] <= total;
         n_ff[0] <= neg;
         o_ff[0] <= (num >= limit);
      end
   end

   for (genvar j = 0; j < CB; j++) begin : g_stage
      localparam int K = CB - 1 - j;
      logic [RW-1:0] dsh;
      logic [RW:0]   trial;
      logic          take;
      assign dsh   = RW'(t_ff[j]) << (FRAC_BITS + K);
      assign trial = {1'b0, r_ff[j]} - {1'b0, dsh};
      assign take  = ~trial[RW];
      always_ff @(posedge clock) begin
         if (en) begin
            r_ff[j+1] <= take ? trial[RW-1:0] : r_ff[j];
            q_ff[j+1] <= {q_ff[j][CB-2:0], take};
            t_ff[j+1] <= t_ff[j];
            n_ff[j+1] <= n_ff[j];
            o_ff[j+1] <= o_ff[j];
         end
      end
   end

   // Overflow magnitudes are clamped far enough out that the later add saturates.
   logic [CB+1:0] magx;
   logic [CB+1:0] carry;
   always_comb begin
      magx  = o_ff[CB] ? (CB+2)'({1'b1, {CB{1'b0}}}) : (CB+2)'(q_ff[CB]);
      carry = (CB+2)'(r_ff[CB] != '0);
      quo   = n_ff[CB] ? $signed((CB+2)'(0) - magx - carry) : $signed(magx);
   end
endmodule

[sv/pcr_front.sv]
// Front pipeline: separating velocity, impulse size and the divider numerators.
`timescale 1ns / 1ps
module pcr_front #(
   parameter int COMPONENT_BITS = 21
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          adv,
   input  logic                                          in_valid,
   input  logic [3*COMPONENT_BITS-1:0]                   va,
   input  logic [3*COMPONENT_BITS-1:0]                   vb,
   input  logic [3*COMPONENT_BITS-1:0]                   pa,
   input  logic [3*COMPONENT_BITS-1:0]                   pb,
   input  logic [3*COMPONENT_BITS-1:0]                   nrm,
   input  logic signed [pcr_pkg::PEN_W-1:0]              pen,
   input  logic [pcr_pkg::MASS_W-1:0]                    ima,
   input  logic [pcr_pkg::MASS_W-1:0]                    imb,
   input  logic                                          has,
   input  logic [pcr_pkg::REST_W-1:0]                    restitution,
   output pcr_pkg::pcr_flags_type                        out_flags,
   output logic [3*COMPONENT_BITS-1:0]                   out_va,
   output logic [3*COMPONENT_BITS-1:0]                   out_vb,
   output logic [3*COMPONENT_BITS-1:0]                   out_pa,
   output logic [3*COMPONENT_BITS-1:0]                   out_pb,
   output logic [pcr_pkg::TOTAL_W-1:0]                   out_total,
   output logic [pcr_pkg::LANES-1:0][COMPONENT_BITS+39:0] out_mag,
   output logic [pcr_pkg::LANES-1:0]                     out_neg
);
   import pcr_pkg::*;

   localparam int CB   = COMPONENT_BITS;
   localparam int SEPP = 2 * CB + 1;
   localparam int SEPW = 2 * CB + 3;
   localparam int NGW  = 2 * CB + 1;
   localparam int PRW  = NGW + FACTOR_W;
   localparam int NDW  = CB + DELTA_W + 1;
   localparam int QPW  = CB + PEN_W;
   localparam int PW   = CB + 24;
   localparam int MW   = CB + 40;

   typedef struct packed {
      pcr_flags_type             flags;
      logic [3*CB-1:0]           va;
      logic [3*CB-1:0]           vb;
      logic [3*CB-1:0]           pa;
      logic [3*CB-1:0]           pb;
      logic [3*CB-1:0]           n;
      logic signed [PEN_W-1:0]   pen;
      logic [MASS_W-1:0]         ima;
      logic [MASS_W-1:0]         imb;
      logic [TOTAL_W-1:0]        total;
   } carry_type;

   carry_type c_ff [1:8];
   carry_type c1_in;
   carry_type c3_in;

   logic signed [CB:0]       rel_ff   [AXES];
   logic signed [CB:0]       rel_in   [AXES];
   logic signed [SEPP-1:0]   rp_ff    [AXES];
   logic signed [SEPP-1:0]   rp_in    [AXES];
   logic [NGW-1:0]           negsep_ff, negsep_in;
   logic                     closing;
   logic [PRW-1:0]           prod_ff, prod_in;
   logic [DELTA_W-1:0]       delta_ff, delta_in;
   logic signed [NDW-1:0]    nd_ff    [AXES];
   logic signed [NDW-1:0]    nd_in    [AXES];
   logic signed [QPW-1:0]    qp_ff    [AXES];
   logic signed [QPW-1:0]    qp_in    [AXES];
   logic [PW-1:0]            absp_ff  [AXES];
   logic [PW-1:0]            absp_in  [AXES];
   logic [PW-1:0]            absq_ff  [AXES];
   logic [PW-1:0]            absq_in  [AXES];
   logic [AXES-1:0]          pneg_ff, pneg_in, qneg_ff, qneg_in;
   logic [LANES-1:0][MW-1:0] mag_ff, mag_in;
   logic [LANES-1:0]         neg_ff, neg_in;

   // Stage 1: capture, mass total and relative velocity.
   always_comb begin
      logic signed [CB:0] ea;
      logic signed [CB:0] eb;
      logic [MASS_W-1:0]  imb_eff;
      imb_eff            = has ? imb : '0;
      c1_in.flags.valid  = in_valid;
      c1_in.flags.has    = has;
      c1_in.flags.imp    = 1'b0;
      c1_in.va           = va;
      c1_in.vb           = vb;
      c1_in.pa           = pa;
      c1_in.pb           = pb;
      c1_in.n            = nrm;
      c1_in.pen          = pen;
      c1_in.ima          = ima;
      c1_in.imb          = imb_eff;
      c1_in.total        = TOTAL_W'(ima) + TOTAL_W'(imb_eff);
      c1_in.flags.mov    = (c1_in.total != '0) && (pen > 0);
      for (int i = 0; i < AXES; i++) begin
         ea        = $signed({va[i*CB+CB-1], va[i*CB +: CB]});
         eb        = has ? $signed({vb[i*CB+CB-1], vb[i*CB +: CB]}) : '0;
         rel_in[i] = ea - eb;
      end
   end

   // Stage 2: relative velocity times normal, per axis.
   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         rp_in[i] = SEPP'(rel_ff[i]) * SEPP'($signed(c_ff[1].n[i*CB +: CB]));
      end
   end

   // Stage 3: separating velocity and the closing test.
   always_comb begin
      logic signed [SEPW-1:0] s0;
      logic signed [SEPW-1:0] s1;
      logic signed [SEPW-1:0] s2;
      logic signed [SEPW-1:0] sep;
      logic signed [SEPW-1:0] nsep;
      s0        = SEPW'(rp_ff[0]);
      s1        = SEPW'(rp_ff[1]);
      s2        = SEPW'(rp_ff[2]);
      sep       = s0 + s1 + s2;
      nsep      = -sep;
      closing   = (sep <= 0);
      negsep_in = closing ? nsep[NGW-1:0] : '0;
   end

   // The impulse flag joins the item in stage 3, where the closing test is made.
   always_comb begin
      c3_in           = c_ff[2];
      c3_in.flags.imp = closing && (c_ff[2].total != '0);
   end

   // Stage 4: scale by one plus restitution.
   assign prod_in = PRW'(negsep_ff) * PRW'(REST_ONE + FACTOR_W'(restitution));

   // Stage 5: back to Q.24 and clamp the velocity change.
   always_comb begin
      logic [PRW-1:0] sh;
      sh       = prod_ff >> REST_SHIFT;
      delta_in = (sh > PRW'(DELTA_LIMIT)) ? DELTA_LIMIT : sh[DELTA_W-1:0];
   end

   // Stage 6: impulse and correction along the normal.
   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         nd_in[i] = NDW'($signed(c_ff[5].n[i*CB +: CB])) * NDW'($signed({1'b0, delta_ff}));
         qp_in[i] = QPW'($signed(c_ff[5].n[i*CB +: CB])) * QPW'(c_ff[5].pen);
      end
   end

   // Stage 7: floor shift of the impulse, then sign and magnitude.
   always_comb begin
      logic signed [NDW-1:0] p;
      logic signed [NDW-1:0] ap;
      logic signed [QPW-1:0] aq;
      for (int i = 0; i < AXES; i++) begin
         p          = nd_ff[i] >>> FRAC_BITS;
         pneg_in[i] = p[NDW-1];
         ap         = pneg_in[i] ? -p : p;
         absp_in[i] = ap[PW-1:0];
         qneg_in[i] = qp_ff[i][QPW-1];
         aq         = qneg_in[i] ? -qp_ff[i] : qp_ff[i];
         absq_in[i] = PW'(aq[CB+19:0]);
      end
   end

   // Stage 8: weight by inverse mass; particle B takes the opposite sign.
   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         mag_in[VEC_VA*AXES+i] = MW'(absp_ff[i]) * MW'(c_ff[7].ima);
         neg_in[VEC_VA*AXES+i] = pneg_ff[i];
         mag_in[VEC_VB*AXES+i] = MW'(absp_ff[i]) * MW'(c_ff[7].imb);
         neg_in[VEC_VB*AXES+i] = ~pneg_ff[i];
         mag_in[VEC_PA*AXES+i] = MW'(absq_ff[i]) * MW'(c_ff[7].ima);
         neg_in[VEC_PA*AXES+i] = qneg_ff[i];
         mag_in[VEC_PB*AXES+i] = MW'(absq_ff[i]) * MW'(c_ff[7].imb);
         neg_in[VEC_PB*AXES+i] = ~qneg_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 1; k <= 8; k++) begin
            c_ff[k].flags.valid <= 1'b0;
         end
      end else if (adv) begin
         c_ff[1] <= c1_in;
         c_ff[2] <= c_ff[1];
         c_ff[3] <= c3_in;
         for (int k = 4; k <= 8; k++) begin
            c_ff[k] <= c_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rel_ff    <= rel_in;
         rp_ff     <= rp_in;
         negsep_ff <= negsep_in;
         prod_ff   <= prod_in;
         delta_ff  <= delta_in;
         nd_ff     <= nd_in;
         qp_ff     <= qp_in;
         absp_ff   <= absp_in;
         absq_ff   <= absq_in;
         pneg_ff   <= pneg_in;
         qneg_ff   <= qneg_in;
         mag_ff    <= mag_in;
         neg_ff    <= neg_in;
      end
   end

   assign out_flags = c_ff[8].flags;
   assign out_va    = c_ff[8].va;
   assign out_vb    = c_ff[8].vb;
   assign out_pa    = c_ff[8].pa;
   assign out_pb    = c_ff[8].pb;
   assign out_total = c_ff[8].total;
   assign out_mag   = mag_ff;
   assign out_neg   = neg_ff;
endmodule

[sv/particle_contact_resolver.sv]
// Top level of the particle contact resolver: ports, divider lanes and result register.
`timescale 1ns / 1ps
// Usage: one contact item arrives on the req_ stream and one resolved item leaves
// on the rsp_ stream for each one accepted, in order. The restitution register is
// written through the csr_ channel, which is always ready; write it only while the
// block holds no items in flight. Reset clears the restitution to zero and empties
// the pipeline.
// Items pass through the front arithmetic (velocity dot product, impulse scaling,
// normal products and mass weighting), the restoring divider lanes that retire one
// quotient bit per stage, and the result register.
// Throughput is one item per clock while the receiver does not stall: every stage
// registers its own item and twelve divider lanes run side by side.
// When the receiver stalls with a result waiting, the whole pipeline holds in place
// and req_tready drops in the same cycle; nothing is lost or repeated, and items
// flow on as soon as rsp_tready returns.
module particle_contact_resolver #(
   parameter int COMPONENT_BITS = 21
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // Fields from bit 0: velocity_a[62:0], velocity_b[125:63], position_a[188:126],
   // position_b[251:189], contact_normal[314:252], penetration_depth[335:315],
   // inv_mass_a[351:336], inv_mass_b[367:352].
   input  logic [367:0] req_tdata,
   // Fields from bit 0: has_second.
   input  logic [0:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // Fields from bit 0: new_velocity_a[62:0], new_velocity_b[125:63],
   // new_position_a[188:126], new_position_b[251:189], zero fill [255:252].
   output logic [255:0] rsp_tdata,
   // Fields from bit 0: impulse_applied, moved_apart.
   output logic [1:0]   rsp_tuser,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [15:0]  csr_data
);
   import pcr_pkg::*;

   localparam int CB = COMPONENT_BITS;
   localparam int MW = CB + 40;
   localparam int SW = CB + 3;

   typedef struct packed {
      pcr_flags_type   flags;
      logic [3*CB-1:0] va;
      logic [3*CB-1:0] vb;
      logic [3*CB-1:0] pa;
      logic [3*CB-1:0] pb;
   } side_type;

   logic                     adv;
   logic [REST_W-1:0]        restitution_ff;
   pcr_flags_type            f_flags;
   logic [3*CB-1:0]          f_va, f_vb, f_pa, f_pb;
   logic [TOTAL_W-1:0]       f_total;
   logic [LANES-1:0][MW-1:0] f_mag;
   logic [LANES-1:0]         f_neg;
   logic signed [CB+1:0]     quo [LANES];
   side_type                 side_ff [0:CB];
   side_type                 side0_in;

   logic                     rsp_tvalid_ff;
   logic [255:0]             rsp_tdata_ff, rsp_tdata_in;
   logic [1:0]               rsp_tuser_ff;

   // The pipeline moves whenever the result register is empty or being drained.
   assign adv        = ~rsp_tvalid_ff | rsp_tready;
   assign req_tready = adv;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         restitution_ff <= '0;
      end else if (csr_valid) begin
         restitution_ff <= csr_data;
      end
   end

   pcr_front #(.COMPONENT_BITS(CB)) u_front (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .in_valid    (req_tvalid),
      .va          (req_tdata[0*VEC_W +: 3*CB]),
      .vb          (req_tdata[1*VEC_W +: 3*CB]),
      .pa          (req_tdata[2*VEC_W +: 3*CB]),
      .pb          (req_tdata[3*VEC_W +: 3*CB]),
      .nrm         (req_tdata[4*VEC_W +: 3*CB]),
      .pen         ($signed(req_tdata[5*VEC_W +: PEN_W])),
      .ima         (req_tdata[5*VEC_W+PEN_W +: MASS_W]),
      .imb         (req_tdata[5*VEC_W+PEN_W+MASS_W +: MASS_W]),
      .has         (req_tuser[0]),
      .restitution (restitution_ff),
      .out_flags   (f_flags),
      .out_va      (f_va),
      .out_vb      (f_vb),
      .out_pa      (f_pa),
      .out_pb      (f_pb),
      .out_total   (f_total),
      .out_mag     (f_mag),
      .out_neg     (f_neg)
   );

   // Each lane divides one weighted component by the total inverse mass.
   for (genvar l = 0; l < LANES; l++) begin : g_lane
      pcr_div #(.COMPONENT_BITS(CB)) u_div (
         .clock (clock),
         .en    (adv),
         .num   (f_mag[l]),
         .neg   (f_neg[l]),
         .total (f_total),
         .quo   (quo[l])
      );
   end

   // The original vectors and flags ride alongside the divider lanes.
   always_comb begin
      side0_in.flags = f_flags;
      side0_in.va    = f_va;
      side0_in.vb    = f_vb;
      side0_in.pa    = f_pa;
      side0_in.pb    = f_pb;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= CB; k++) begin
            side_ff[k].flags.valid <= 1'b0;
         end
      end else if (adv) begin
         side_ff[0] <= side0_in;
         for (int k = 1; k <= CB; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // Add each quotient to its base component, saturate, and keep the base where
   // the impulse or the correction does not apply or particle B is absent.
   always_comb begin
      logic [3*CB-1:0]        base  [VECS];
      logic [3*CB-1:0]        res   [VECS];
      logic                   use_v [VECS];
      logic signed [SW-1:0]   b;
      logic signed [SW-1:0]   q;
      logic signed [SW-1:0]   s;
      logic signed [SW-1:0]   hi;
      logic signed [SW-1:0]   lo;
      side_type               sd;
      sd    = side_ff[CB];
      base[VEC_VA] = sd.va;
      base[VEC_VB] = sd.vb;
      base[VEC_PA] = sd.pa;
      base[VEC_PB] = sd.pb;
      use_v[VEC_VA] = sd.flags.imp;
      use_v[VEC_VB] = sd.flags.imp & sd.flags.has;
      use_v[VEC_PA] = sd.flags.mov;
      use_v[VEC_PB] = sd.flags.mov & sd.flags.has;
      hi = SW'((1 << (CB - 1)) - 1);
      lo = -SW'(1 << (CB - 1));
      for (int v = 0; v < VECS; v++) begin
         for (int i = 0; i < AXES; i++) begin
            b = SW'($signed(base[v][i*CB +: CB]));
            q = SW'(quo[v*AXES+i]);
            s = b + q;
            if (!use_v[v]) begin
               res[v][i*CB +: CB] = base[v][i*CB +: CB];
            end else if (s > hi) begin
               res[v][i*CB +: CB] = hi[CB-1:0];
            end else if (s < lo) begin
               res[v][i*CB +: CB] = lo[CB-1:0];
            end else begin
               res[v][i*CB +: CB] = s[CB-1:0];
            end
         end
      end
      rsp_tdata_in = '0;
      for (int v = 0; v < VECS; v++) begin
         rsp_tdata_in[v*VEC_W +: VEC_W] = VEC_W'(res[v]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (adv) begin
         rsp_tvalid_ff <= side_ff[CB].flags.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_tdata_ff <= rsp_tdata_in;
         rsp_tuser_ff <= {side_ff[CB].flags.mov, side_ff[CB].flags.imp};
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;
endmodule

[sim/pcr_checker.sv]
// Checker for the particle contact resolver: predicts each resolved contact and compares.
`timescale 1ns / 1ps
module pcr_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [367:0] req_tdata,
   input  logic [0:0]   req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [255:0] rsp_tdata,
   input  logic [1:0]   rsp_tuser,
   input  logic         csr_valid,
   input  logic         csr_ready,
   input  logic [15:0]  csr_data,
   output int           fails,
   output int           pending
);
   import pcr_pkg::*;

   typedef logic signed [127:0] wide_type;

   typedef struct {
      logic [VEC_W-1:0] vel_a, vel_b, pos_a, pos_b;
      logic             imp, mov;
   } contact_result_type;

   contact_result_type resolved_q[$];
   logic [REST_W-1:0] restitution;

   function automatic wide_type comp(input logic [VEC_W-1:0] v, input int i);
      return wide_type'($signed(v[i*21 +: 21]));
   endfunction

   function automatic wide_type clamp21(input wide_type x);
      if (x > 1048575) return 1048575;
      if (x < -1048576) return -1048576;
      return x;
   endfunction

   function automatic wide_type floor_div(input wide_type a, input wide_type b);
      wide_type q;
      q = a / b;
      if ((a % b) != 0 && a < 0) q = q - 1;
      return q;
   endfunction

   function automatic contact_result_type resolve(input logic [367:0] d, input logic has,
                                                  input logic [REST_W-1:0] rest);
      contact_result_type r;
      wide_type va[3], vb[3], pa[3], pb[3], n[3];
      wide_type pen, ima, imb, total, den, sep, delta, p, q;
      for (int i = 0; i < 3; i++) begin
         va[i] = comp(d[62:0], i);
         vb[i] = comp(d[125:63], i);
         pa[i] = comp(d[188:126], i);
         pb[i] = comp(d[251:189], i);
         n[i]  = comp(d[314:252], i);
      end
      pen   = wide_type'($signed(d[335:315]));
      ima   = wide_type'(d[351:336]);
      imb   = wide_type'(d[367:352]);
      total = ima + (has ? imb : 0);
      r.imp = 1'b0;
      r.mov = 1'b0;
      if (total > 0) begin
         den = total <<< FRAC_BITS;
         sep = 0;
         for (int i = 0; i < 3; i++) sep = sep + (va[i] - (has ? vb[i] : 0)) * n[i];
         // Closing or resting contact: the restitution impulse acts along the normal.
         if (sep <= 0) begin
            delta = ((-sep) * (32768 + wide_type'(rest))) >>> REST_SHIFT;
            if (delta > (wide_type'(1) <<< 36)) delta = wide_type'(1) <<< 36;
            r.imp = 1'b1;
            for (int i = 0; i < 3; i++) begin
               p = (n[i] * delta) >>> FRAC_BITS;
               va[i] = clamp21(va[i] + floor_div(p * ima, den));
               if (has) vb[i] = clamp21(vb[i] + floor_div(-p * imb, den));
            end
         end
         if (pen > 0) begin
            r.mov = 1'b1;
            for (int i = 0; i < 3; i++) begin
               q = n[i] * pen;
               pa[i] = clamp21(pa[i] + floor_div(q * ima, den));
               if (has) pb[i] = clamp21(pb[i] + floor_div(-q * imb, den));
            end
         end
      end
      for (int i = 0; i < 3; i++) begin
         r.vel_a[i*21 +: 21] = va[i][20:0];
         r.vel_b[i*21 +: 21] = vb[i][20:0];
         r.pos_a[i*21 +: 21] = pa[i][20:0];
         r.pos_b[i*21 +: 21] = pb[i][20:0];
      end
      return r;
   endfunction

   assign pending = resolved_q.size();

   always @(posedge clock) begin
      contact_result_type want;
      contact_result_type got;
      if (reset) begin
         restitution <= '0;
         resolved_q.delete();
         fails <= 0;
      end else begin
         if (csr_valid && csr_ready) restitution <= csr_data;
         if (req_tvalid && req_tready)
            resolved_q.push_back(resolve(req_tdata, req_tuser[0], restitution));
         if (rsp_tvalid && rsp_tready) begin
            got.vel_a = rsp_tdata[62:0];
            got.vel_b = rsp_tdata[125:63];
            got.pos_a = rsp_tdata[188:126];
            got.pos_b = rsp_tdata[251:189];
            got.imp   = rsp_tuser[0];
            got.mov   = rsp_tuser[1];
            if (resolved_q.size() == 0) begin
               if (fails < 10) $display("unexpected result %h / %b", rsp_tdata, rsp_tuser);
               fails <= fails + 1;
            end else begin
               want = resolved_q.pop_front();
               if (want.vel_a !== got.vel_a || want.vel_b !== got.vel_b ||
                   want.pos_a !== got.pos_a || want.pos_b !== got.pos_b ||
                   want.imp !== got.imp || want.mov !== got.mov ||
                   rsp_tdata[255:252] !== 4'b0) begin
                  if (fails < 10) begin
                     $display("mismatch: expected va %h vb %h pa %h pb %h imp %b mov %b",
                              want.vel_a, want.vel_b, want.pos_a, want.pos_b,
                              want.imp, want.mov);
                     $display("          actual   va %h vb %h pa %h pb %h imp %b mov %b",
                              got.vel_a, got.vel_b, got.pos_a, got.pos_b,
                              got.imp, got.mov);
                  end
                  fails <= fails + 1;
               end
            end
         end
      end
   end
endmodule

[sim/tb_particle_contact_resolver.sv]
// Testbench top for the particle contact resolver: stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps
module tb_particle_contact_resolver;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 40;

   logic         clock;
   logic         reset;
   logic         req_tvalid, req_tready;
   logic [367:0] req_tdata;
   logic [0:0]   req_tuser;
   logic         rsp_tvalid, rsp_tready;
   logic [255:0] rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         csr_valid, csr_ready;
   logic [15:0]  csr_data;
   int           fails, pending;
   logic         quiet, hold_rsp;
   int           idle_cycles;

   particle_contact_resolver dut (.*);

   pcr_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Packs three Q8.12 components, x in the low bits.
   function automatic logic [62:0] vec3(input int x, input int y, input int z);
      logic [20:0] a, b, c;
      a = x[20:0];
      b = y[20:0];
      c = z[20:0];
      return {c, b, a};
   endfunction

   function automatic logic [62:0] rand_vec();
      int k;
      k = $urandom_range(0, 3);
      if (k == 0) return 63'({$urandom(), $urandom()});
      return vec3($urandom_range(0, 131072) - 65536, $urandom_range(0, 131072) - 65536,
                  $urandom_range(0, 131072) - 65536);
   endfunction

   // Mostly near-unit normals; sometimes raw bits, which can drive the impulse to its limit.
   function automatic logic [62:0] rand_normal();
      int k, s;
      k = $urandom_range(0, 5);
      s = $urandom_range(0, 1) ? 4096 : -4096;
      case (k)
         0, 1: begin
            case ($urandom_range(0, 2))
               0: return vec3(s, 0, 0);
               1: return vec3(0, s, 0);
               default: return vec3(0, 0, s);
            endcase
         end
         2: return vec3($urandom_range(0, 1) ? 2896 : -2896, 2896, 0);
         3, 4: return vec3($urandom_range(0, 8192) - 4096, $urandom_range(0, 8192) - 4096,
                           $urandom_range(0, 8192) - 4096);
         default: return 63'({$urandom(), $urandom()});
      endcase
   endfunction

   function automatic logic [15:0] rand_mass();
      case ($urandom_range(0, 5))
         0: return 16'd0;
         1: return 16'hFFFF;
         default: return 16'($urandom_range(1, 65535));
      endcase
   endfunction

   function automatic logic [20:0] rand_pen();
      case ($urandom_range(0, 4))
         0: return 21'd0;
         1: return 21'($urandom());
         default: return 21'($urandom_range(1, 40000));
      endcase
   endfunction

   // Drives one item from a falling edge and returns at the falling edge after acceptance.
   task automatic send_item(input logic [367:0] d, input logic has);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      req_tdata  = d;
      req_tuser  = has;
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic send_contact(input logic [62:0] va, vb, pa, pb, n, input logic [20:0] pen,
                               input logic [15:0] ima, imb, input logic has);
      send_item({imb, ima, pen, n, pb, pa, vb, va}, has);
   endtask

   task automatic send_random();
      send_contact(rand_vec(), rand_vec(), rand_vec(), rand_vec(), rand_normal(), rand_pen(),
                   rand_mass(), rand_mass(), 1'($urandom_range(0, 1)));
   endtask

   // Lets every item in flight come out before the restitution changes.
   task automatic drain();
      req_tvalid = 1'b0;
      wait (pending == 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_restitution(input logic [15:0] value);
      csr_data  = value;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Receiver side: random stall bursts, one long hold-off on request, none when quiet.
   initial begin
      rsp_tready = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_tready = 1'b0;
            repeat (300) @(negedge clock);
            hold_rsp = 1'b0;
         end else if (!quiet && $urandom_range(0, 4) == 0) begin
            rsp_tready = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clock);
         end else begin
            rsp_tready = 1'b1;
            @(negedge clock);
         end
      end
   end

   // Watchdog: a run with no handshake for too long has hung.
   initial begin
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles = idle_cycles + 1;
      end
      $display("tb_particle_contact_resolver NOT OK");
      $finish;
   end

   initial begin
      logic [15:0] settings[4];
      settings = '{16'd32768, 16'd0, 16'd65535, 16'd0};
      settings[3] = 16'($urandom_range(1, 32767));
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      csr_valid  = 1'b0;
      csr_data   = '0;
      quiet      = 1'b0;
      hold_rsp   = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed contacts at the reset restitution of zero.
      // Immovable on both sides: nothing changes.
      send_contact(vec3(4096, 0, 0), vec3(-4096, 0, 0), 0, 0, vec3(-4096, 0, 0),
                   21'd4096, 0, 0, 1);
      // Second particle absent, so its mass does not count and the total is zero.
      send_contact(vec3(4096, 0, 0), 0, 0, 0, vec3(-4096, 0, 0), 21'd4096, 0, 16'd4096, 0);
      // Head-on closing contact with overlap.
      send_contact(vec3(4096, 0, 0), vec3(-4096, 0, 0), 0, vec3(8192, 0, 0),
                   vec3(-4096, 0, 0), 21'd2048, 16'd4096, 16'd4096, 1);
      // Separating contact: velocities stay.
      send_contact(vec3(-4096, 0, 0), vec3(4096, 0, 0), 0, 0, vec3(-4096, 0, 0),
                   21'd0, 16'd4096, 16'd4096, 1);
      // Resting contact: equal velocities, zero impulse but the flag is set.
      send_contact(vec3(100, 200, 300), vec3(100, 200, 300), 0, 0, vec3(0, 4096, 0),
                   21'h1FFFFF, 16'd4096, 16'd2048, 1);
      // Scenery contact against a floor.
      send_contact(vec3(0, -8192, 0), vec3(1, 2, 3), vec3(5, 6, 7), vec3(-1, -2, -3),
                   vec3(0, 4096, 0), 21'd500, 16'd4096, 16'hFFFF, 0);
      // Largest penetration and masses, extreme positions that saturate.
      send_contact(vec3(-1048576, 1048575, 0), vec3(1048575, -1048576, 0),
                   vec3(1048575, -1048576, 1048575), vec3(-1048576, 1048575, -1048576),
                   vec3(4096, -4096, 4096), 21'h0FFFFF, 16'hFFFF, 16'hFFFF, 1);
      // Most negative penetration.
      send_contact(vec3(0, 0, 4096), 0, 0, 0, vec3(0, 0, -4096), 21'h100000, 16'd1,
                   16'hFFFF, 1);
      // Far from unit normal with large closing speed: the change hits its limit.
      send_contact(vec3(1048575, 1048575, 1048575), vec3(-1048576, -1048576, -1048576), 0, 0,
                   vec3(-1048576, -1048576, -1048576), 21'd1, 16'd1, 16'd1, 1);
      send_contact(vec3(-1048576, -1048576, -1048576), 0, 0, 0,
                   vec3(1048575, 1048575, 1048575), 21'd1, 16'hFFFF, 16'd0, 0);
      // All ones and all zeros across every field.
      send_item({368{1'b1}}, 1'b1);
      send_item('0, 1'b0);
      send_item({368{1'b1}}, 1'b0);
      for (int i = 0; i < 8; i++) send_random();

      for (int ph = 0; ph < 4; ph++) begin
         drain();
         write_restitution(settings[ph]);
         quiet = (ph == 3);
         for (int i = 0; i < 150; i++) begin
            // The receiver holds off while items keep coming, filling the pipeline.
            if (ph == 0 && i == 40) hold_rsp = 1'b1;
            // The sender waits out every result before going on.
            if (ph == 1 && i == 60) begin
               req_tvalid = 1'b0;
               wait (pending == 0);
               @(negedge clock);
            end
            send_random();
         end
      end

      req_tvalid = 1'b0;
      wait (pending == 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fails == 0)
         $display("tb_particle_contact_resolver OK");
      else
         $display("tb_particle_contact_resolver NOT OK");
      $finish;
   end
endmodule
